FILE: rtl/cdan_pkg.sv
// ----------------------------------------------------------------------------
// cdan_pkg
// Shared widths, constants, handshake structs and calendar helpers for the
// date-time add and normalize block.
// ----------------------------------------------------------------------------
package cdan_pkg;

    localparam int unsigned CDAN_MAX_YEAR = 9999;

    // Payload widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned AYEAR_W  = 14;
    localparam int unsigned AMONTH_W = 12;
    localparam int unsigned ADD_W    = 16;

    // Working widths
    localparam int unsigned WORK_W = 17;    // carried sums and year during the walk
    localparam int unsigned MCNT_W = 13;    // 0-based month count before carry

    // Shared divider
    localparam int unsigned DIV_DW = WORK_W;
    localparam int unsigned DIV_RW = 9;
    localparam int unsigned RCP_W  = 18;

    localparam logic [DIV_RW-1:0] DIV_SEC  = DIV_RW'(60);
    localparam logic [DIV_RW-1:0] DIV_MIN  = DIV_RW'(60);
    localparam logic [DIV_RW-1:0] DIV_HOUR = DIV_RW'(24);
    localparam logic [DIV_RW-1:0] DIV_MON  = DIV_RW'(12);
    localparam logic [DIV_RW-1:0] DIV_LEAP = DIV_RW'(400);

    // Reciprocals: q = (x * RCP) >> RSH, exact for any 17-bit x
    localparam logic [RCP_W-1:0] RCP_60  = RCP_W'(139811);
    localparam logic [RCP_W-1:0] RCP_24  = RCP_W'(174763);
    localparam logic [RCP_W-1:0] RCP_12  = RCP_W'(174763);
    localparam logic [RCP_W-1:0] RCP_400 = RCP_W'(167773);

    localparam int unsigned RSH_60  = 23;
    localparam int unsigned RSH_24  = 22;
    localparam int unsigned RSH_12  = 21;
    localparam int unsigned RSH_400 = 26;

    // 0-based month codes
    localparam logic [MONTH_W-1:0] MON_FEB = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MON_APR = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MON_JUN = MONTH_W'(5);
    localparam logic [MONTH_W-1:0] MON_SEP = MONTH_W'(8);
    localparam logic [MONTH_W-1:0] MON_NOV = MONTH_W'(10);
    localparam logic [MONTH_W-1:0] MON_DEC = MONTH_W'(11);

    localparam logic [DIV_RW-1:0] Y400_C100 = DIV_RW'(100);
    localparam logic [DIV_RW-1:0] Y400_C200 = DIV_RW'(200);
    localparam logic [DIV_RW-1:0] Y400_C300 = DIV_RW'(300);
    localparam logic [DIV_RW-1:0] Y400_LAST = DIV_RW'(399);

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_RW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
        logic [DIV_RW-1:0] rem;
    } div_rsp_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon0,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (mon0) inside
            MON_FEB:                          len = leap ? DAY_W'(29) : DAY_W'(28);
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
            default:                          len = DAY_W'(31);
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/cdan_if.sv
// ----------------------------------------------------------------------------
// cdan_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface cdan_in_if import cdan_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SEC_W-1:0]    second;
    logic [AYEAR_W-1:0]  add_years;
    logic [AMONTH_W-1:0] add_months;
    logic [ADD_W-1:0]    add_days;
    logic [ADD_W-1:0]    add_hours;
    logic [ADD_W-1:0]    add_minutes;
    logic [ADD_W-1:0]    add_seconds;

    modport source (
        output valid, year, month, day, hour, minute, second,
               add_years, add_months, add_days, add_hours, add_minutes, add_seconds,
        input  ready
    );
    modport sink (
        input  valid, year, month, day, hour, minute, second,
               add_years, add_months, add_days, add_hours, add_minutes, add_seconds,
        output ready
    );
endinterface

interface cdan_out_if import cdan_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [HOUR_W-1:0]  out_hour;
    logic [MIN_W-1:0]   out_minute;
    logic [SEC_W-1:0]   out_second;
    logic               clamped;

    modport source (
        output valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
               clamped,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
               clamped,
        output ready
    );
endinterface

FILE: rtl/cdan_div.sv
// ----------------------------------------------------------------------------
// cdan_div
// Divider by the fixed calendar constants on one shared multiplier: a
// reciprocal pass for the quotient, then a pass for quotient times divisor
// to get the remainder. done pulses for one cycle, registered with the remainder.
// ----------------------------------------------------------------------------
module cdan_div import cdan_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned PROD_W = DIV_DW + RCP_W;

    logic              busy_reg, busy_next;
    logic              rpass_reg, rpass_next;
    logic              done_reg, done_next;
    logic [DIV_DW-1:0] num_reg, num_next;
    logic [DIV_RW-1:0] dvs_reg, dvs_next;
    logic [DIV_DW-1:0] quo_reg, quo_next;
    logic [DIV_RW-1:0] rem_reg, rem_next;

    logic [RCP_W-1:0]  rcp;
    logic [DIV_DW-1:0] qsel;
    logic [DIV_DW-1:0] mul_a;
    logic [RCP_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;
    logic [DIV_DW-1:0] diff;

    assign mul_a = rpass_reg ? quo_reg : num_reg;
    assign mul_b = rpass_reg ? RCP_W'(dvs_reg) : rcp;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign diff  = num_reg - prod[DIV_DW-1:0];

    always_comb
    begin
        case (dvs_reg)
            DIV_SEC:
            begin
                rcp  = RCP_60;
                qsel = DIV_DW'(prod[PROD_W-1:RSH_60]);
            end
            DIV_HOUR:
            begin
                rcp  = RCP_24;
                qsel = DIV_DW'(prod[PROD_W-1:RSH_24]);
            end
            DIV_MON:
            begin
                rcp  = RCP_12;
                qsel = DIV_DW'(prod[PROD_W-1:RSH_12]);
            end
            DIV_LEAP:
            begin
                rcp  = RCP_400;
                qsel = DIV_DW'(prod[PROD_W-1:RSH_400]);
            end
            default:
            begin
                rcp  = RCP_60;
                qsel = DIV_DW'(prod[PROD_W-1:RSH_60]);
            end
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        rpass_next = rpass_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        dvs_next   = dvs_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            rpass_next = 1'b0;
            num_next   = req.dividend;
            dvs_next   = req.divisor;
        end
        else if (busy_reg && !rpass_reg)
        begin
            quo_next   = qsel;
            rpass_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = diff[DIV_RW-1:0];
            rpass_next = 1'b0;
            busy_next  = 1'b0;
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rpass_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            rpass_reg <= rpass_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: rtl/calendar_date_add_normalize.sv
// ----------------------------------------------------------------------------
// calendar_date_add_normalize
// Adds year/month/day/hour/minute/second amounts to a Gregorian date-time and
// normalizes the result, clamping above MAX_YEAR.
// ----------------------------------------------------------------------------
// One word at a time. After a word is taken, five divisions by fixed constants
// (seconds, minutes, hours, months carry, and year mod 400 for the leap rule)
// run in turn on a shared reciprocal multiplier, then surplus days are consumed
// one month per cycle. The result is loaded after the month walk, and ready
// returns the cycle after it is loaded. The result sits in an output register;
// a new word is accepted while it waits, and ready is low from acceptance until
// the result is loaded, which holds off while the previous result is unread.
// A year past MAX_YEAR returns MAX_YEAR-12-31 23:59:59 with clamped set.
// ----------------------------------------------------------------------------
module calendar_date_add_normalize import cdan_pkg::*; #(
    parameter int unsigned MAX_YEAR = CDAN_MAX_YEAR
) (
    input  logic clk,
    input  logic rst_n,
    cdan_in_if.sink    din,
    cdan_out_if.source dout
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DSEC  = 8'b0000_0010,
        ST_DMIN  = 8'b0000_0100,
        ST_DHOUR = 8'b0000_1000,
        ST_DMON  = 8'b0001_0000,
        ST_DYEAR = 8'b0010_0000,
        ST_WALK  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    localparam logic [WORK_W-1:0] MAX_Y = WORK_W'(MAX_YEAR);

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   oval_reg, oval_next;

    logic [WORK_W-1:0]  y_reg, y_next;
    logic [MCNT_W-1:0]  m_reg, m_next;
    logic [WORK_W-1:0]  d_reg, d_next;
    logic [WORK_W-1:0]  h_reg, h_next;
    logic [WORK_W-1:0]  mi_reg, mi_next;
    logic [WORK_W-1:0]  s_reg, s_next;
    logic [DIV_RW-1:0]  y400_reg, y400_next;
    logic               clamp_reg, clamp_next;

    logic [YEAR_W-1:0]  oyear_reg, oyear_next;
    logic [MONTH_W-1:0] omon_reg, omon_next;
    logic [DAY_W-1:0]   oday_reg, oday_next;
    logic [HOUR_W-1:0]  ohour_reg, ohour_next;
    logic [MIN_W-1:0]   omin_reg, omin_next;
    logic [SEC_W-1:0]   osec_reg, osec_next;
    logic               oclamp_reg, oclamp_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               accept;
    logic               div_state;
    logic [MONTH_W-1:0] mon0;
    logic [MONTH_W-1:0] in_mon0;
    logic [DAY_W-1:0]   in_day;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               load_out;

    cdan_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign din.ready = (state_reg == ST_IDLE);
    assign accept    = din.valid && din.ready;

    assign mon0    = m_reg[MONTH_W-1:0];
    assign in_mon0 = (din.month == '0) ? '0 : din.month - MONTH_W'(1);
    assign in_day  = (din.day == '0) ? DAY_W'(1) : din.day;
    assign leap    = (y_reg[1:0] == 2'b00) && !(y400_reg == Y400_C100 ||
                     y400_reg == Y400_C200 || y400_reg == Y400_C300);
    assign len     = month_len(mon0, leap);
    assign load_out = (state_reg == ST_OUT) && (!oval_reg || dout.ready);

    assign div_state = (state_reg == ST_DSEC) || (state_reg == ST_DMIN) ||
                       (state_reg == ST_DHOUR) || (state_reg == ST_DMON) ||
                       (state_reg == ST_DYEAR);

    always_comb
    begin
        div_req.start = div_state && !issued_reg;
        unique case (state_reg)
            ST_DSEC:
            begin
                div_req.dividend = s_reg;
                div_req.divisor  = DIV_SEC;
            end
            ST_DMIN:
            begin
                div_req.dividend = mi_reg;
                div_req.divisor  = DIV_MIN;
            end
            ST_DHOUR:
            begin
                div_req.dividend = h_reg;
                div_req.divisor  = DIV_HOUR;
            end
            ST_DMON:
            begin
                div_req.dividend = WORK_W'(m_reg);
                div_req.divisor  = DIV_MON;
            end
            ST_DYEAR:
            begin
                div_req.dividend = y_reg;
                div_req.divisor  = DIV_LEAP;
            end
            default:
            begin
                div_req.dividend = '0;
                div_req.divisor  = DIV_SEC;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        y_next      = y_reg;
        m_next      = m_reg;
        d_next      = d_reg;
        h_next      = h_reg;
        mi_next     = mi_reg;
        s_next      = s_reg;
        y400_next   = y400_reg;
        clamp_next  = clamp_reg;

        if (div_req.start)
            issued_next = 1'b1;
        if (div_rsp.done)
            issued_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    y_next     = WORK_W'(din.year) + WORK_W'(din.add_years);
                    m_next     = MCNT_W'(in_mon0) + MCNT_W'(din.add_months);
                    d_next     = WORK_W'(in_day) + WORK_W'(din.add_days);
                    h_next     = WORK_W'(din.hour) + WORK_W'(din.add_hours);
                    mi_next    = WORK_W'(din.minute) + WORK_W'(din.add_minutes);
                    s_next     = WORK_W'(din.second) + WORK_W'(din.add_seconds);
                    clamp_next = 1'b0;
                    state_next = ST_DSEC;
                end
            end
            ST_DSEC:
            begin
                if (div_rsp.done)
                begin
                    mi_next    = mi_reg + div_rsp.quot;
                    s_next     = WORK_W'(div_rsp.rem);
                    state_next = ST_DMIN;
                end
            end
            ST_DMIN:
            begin
                if (div_rsp.done)
                begin
                    h_next     = h_reg + div_rsp.quot;
                    mi_next    = WORK_W'(div_rsp.rem);
                    state_next = ST_DHOUR;
                end
            end
            ST_DHOUR:
            begin
                if (div_rsp.done)
                begin
                    d_next     = d_reg + div_rsp.quot;
                    h_next     = WORK_W'(div_rsp.rem);
                    state_next = ST_DMON;
                end
            end
            ST_DMON:
            begin
                if (div_rsp.done)
                begin
                    y_next     = y_reg + div_rsp.quot;
                    m_next     = MCNT_W'(div_rsp.rem);
                    state_next = ST_DYEAR;
                end
            end
            ST_DYEAR:
            begin
                if (div_rsp.done)
                begin
                    y400_next  = div_rsp.rem;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (y_reg > MAX_Y)
                begin
                    clamp_next = 1'b1;
                    state_next = ST_OUT;
                end
                else if (d_reg <= WORK_W'(len))
                    state_next = ST_OUT;
                else
                begin
                    d_next = d_reg - WORK_W'(len);
                    if (mon0 == MON_DEC)
                    begin
                        m_next    = '0;
                        y_next    = y_reg + WORK_W'(1);
                        y400_next = (y400_reg == Y400_LAST) ? '0 : y400_reg + DIV_RW'(1);
                    end
                    else
                        m_next = m_reg + MCNT_W'(1);
                end
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        oyear_next  = oyear_reg;
        omon_next   = omon_reg;
        oday_next   = oday_reg;
        ohour_next  = ohour_reg;
        omin_next   = omin_reg;
        osec_next   = osec_reg;
        oclamp_next = oclamp_reg;
        oval_next   = oval_reg && !dout.ready;
        if (load_out)
        begin
            oval_next   = 1'b1;
            oclamp_next = clamp_reg;
            if (clamp_reg)
            begin
                oyear_next = MAX_Y[YEAR_W-1:0];
                omon_next  = MONTH_W'(12);
                oday_next  = DAY_W'(31);
                ohour_next = HOUR_W'(23);
                omin_next  = MIN_W'(59);
                osec_next  = SEC_W'(59);
            end
            else
            begin
                oyear_next = y_reg[YEAR_W-1:0];
                omon_next  = mon0 + MONTH_W'(1);
                oday_next  = d_reg[DAY_W-1:0];
                ohour_next = h_reg[HOUR_W-1:0];
                omin_next  = mi_reg[MIN_W-1:0];
                osec_next  = s_reg[SEC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        h_reg      <= h_next;
        mi_reg     <= mi_next;
        s_reg      <= s_next;
        y400_reg   <= y400_next;
        clamp_reg  <= clamp_next;
        oyear_reg  <= oyear_next;
        omon_reg   <= omon_next;
        oday_reg   <= oday_next;
        ohour_reg  <= ohour_next;
        omin_reg   <= omin_next;
        osec_reg   <= osec_next;
        oclamp_reg <= oclamp_next;
    end

    assign dout.valid      = oval_reg;
    assign dout.out_year   = oyear_reg;
    assign dout.out_month  = omon_reg;
    assign dout.out_day    = oday_reg;
    assign dout.out_hour   = ohour_reg;
    assign dout.out_minute = omin_reg;
    assign dout.out_second = osec_reg;
    assign dout.clamped    = oclamp_reg;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives date-time words with add amounts into calendar_date_add_normalize
// and checks every result word against an in-bench calendar model: carries,
// month walk with the leap rule, and the clamp above the last year.
// ----------------------------------------------------------------------------
module testbench import cdan_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FEB = 2;
    localparam int unsigned APR = 4;
    localparam int unsigned JUN = 6;
    localparam int unsigned SEP = 9;
    localparam int unsigned NOV = 11;
    localparam int unsigned DEC = 12;

    typedef struct {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
        logic [AYEAR_W-1:0]  add_years;
        logic [AMONTH_W-1:0] add_months;
        logic [ADD_W-1:0]    add_days;
        logic [ADD_W-1:0]    add_hours;
        logic [ADD_W-1:0]    add_minutes;
        logic [ADD_W-1:0]    add_seconds;
    } date_in_t;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic               clamped;
    } date_out_t;

    class date_sum_board;
        date_out_t   expected_q[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        function date_out_t normalize_sum(date_in_t w);
            int unsigned yr, mo, dy, hr, mn, sc, mlen;
            bit          leap;
            date_out_t   r;
            yr = int'(w.year) + int'(w.add_years);
            mo = (w.month == 0) ? 1 : int'(w.month);
            mo += int'(w.add_months);
            dy = (w.day == 0) ? 1 : int'(w.day);
            dy += int'(w.add_days);
            hr = int'(w.hour) + int'(w.add_hours);
            mn = int'(w.minute) + int'(w.add_minutes);
            sc = int'(w.second) + int'(w.add_seconds);
            mn += sc / 60;
            sc %= 60;
            hr += mn / 60;
            mn %= 60;
            dy += hr / 24;
            hr %= 24;
            yr += (mo - 1) / 12;
            mo = (mo - 1) % 12 + 1;
            while (yr <= CDAN_MAX_YEAR)
            begin
                leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
                if (mo == FEB)
                    mlen = leap ? 29 : 28;
                else if (mo == APR || mo == JUN || mo == SEP || mo == NOV)
                    mlen = 30;
                else
                    mlen = 31;
                if (dy <= mlen)
                    break;
                dy -= mlen;
                mo++;
                if (mo == DEC + 1)
                begin
                    mo = 1;
                    yr++;
                end
            end
            r.clamped = (yr > CDAN_MAX_YEAR);
            if (r.clamped)
            begin
                yr = CDAN_MAX_YEAR;
                mo = DEC;
                dy = 31;
                hr = 23;
                mn = 59;
                sc = 59;
            end
            r.year   = YEAR_W'(yr);
            r.month  = MONTH_W'(mo);
            r.day    = DAY_W'(dy);
            r.hour   = HOUR_W'(hr);
            r.minute = MIN_W'(mn);
            r.second = SEC_W'(sc);
            return r;
        endfunction

        function void note_word(date_in_t w);
            expected_q.push_back(normalize_sum(w));
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                fail_count++;
            end
        endfunction

        function void check_word(date_out_t got);
            date_out_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result word with no word outstanding");
                fail_count++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("out_year", 32'(exp_r.year), 32'(got.year));
            compare_field("out_month", 32'(exp_r.month), 32'(got.month));
            compare_field("out_day", 32'(exp_r.day), 32'(got.day));
            compare_field("out_hour", 32'(exp_r.hour), 32'(got.hour));
            compare_field("out_minute", 32'(exp_r.minute), 32'(got.minute));
            compare_field("out_second", 32'(exp_r.second), 32'(got.second));
            compare_field("clamped", 32'(exp_r.clamped), 32'(got.clamped));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    cdan_in_if  in_ch();
    cdan_out_if out_ch();

    calendar_date_add_normalize dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (in_ch),
        .dout  (out_ch)
    );

    date_sum_board board = new();
    int unsigned   burst_left = 0;
    int unsigned   cycle_cnt = 0;
    int unsigned   stall_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: check accepted words, then pick next ready
    always @(posedge clk)
    begin
        date_out_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.year    = out_ch.out_year;
            got.month   = out_ch.out_month;
            got.day     = out_ch.out_day;
            got.hour    = out_ch.out_hour;
            got.minute  = out_ch.out_minute;
            got.second  = out_ch.out_second;
            got.clamped = out_ch.clamped;
            board.check_word(got);
        end
        cycle_cnt++;
        case ((cycle_cnt / 700) % 3)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 40);
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    function automatic date_in_t build_word(
        int unsigned y, int unsigned mo, int unsigned d,
        int unsigned h, int unsigned mi, int unsigned s,
        int unsigned ay, int unsigned am, int unsigned ad,
        int unsigned ah, int unsigned ami, int unsigned as_
    );
        date_in_t w;
        w.year        = YEAR_W'(y);
        w.month       = MONTH_W'(mo);
        w.day         = DAY_W'(d);
        w.hour        = HOUR_W'(h);
        w.minute      = MIN_W'(mi);
        w.second      = SEC_W'(s);
        w.add_years   = AYEAR_W'(ay);
        w.add_months  = AMONTH_W'(am);
        w.add_days    = ADD_W'(ad);
        w.add_hours   = ADD_W'(ah);
        w.add_minutes = ADD_W'(ami);
        w.add_seconds = ADD_W'(as_);
        return w;
    endfunction

    function automatic int unsigned pick_amount(int unsigned common_max, int unsigned rare_max);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, rare_max);
        return $urandom_range(0, common_max);
    endfunction

    function automatic int unsigned any_bits(int unsigned width);
        return $urandom_range(0, (1 << width) - 1);
    endfunction

    task automatic send_word(input date_in_t w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 20);
                6, 7:             gap = 0;
                8:                gap = $urandom_range(50, 400);
                default:          gap = $urandom_range(1, 3);
            endcase
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.year        <= w.year;
        in_ch.month       <= w.month;
        in_ch.day         <= w.day;
        in_ch.hour        <= w.hour;
        in_ch.minute      <= w.minute;
        in_ch.second      <= w.second;
        in_ch.add_years   <= w.add_years;
        in_ch.add_months  <= w.add_months;
        in_ch.add_days    <= w.add_days;
        in_ch.add_hours   <= w.add_hours;
        in_ch.add_minutes <= w.add_minutes;
        in_ch.add_seconds <= w.add_seconds;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_word(w);
    endtask

    initial
    begin
        date_in_t w;
        int unsigned kind;
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.year        <= '0;
        in_ch.month       <= '0;
        in_ch.day         <= '0;
        in_ch.hour        <= '0;
        in_ch.minute      <= '0;
        in_ch.second      <= '0;
        in_ch.add_years   <= '0;
        in_ch.add_months  <= '0;
        in_ch.add_days    <= '0;
        in_ch.add_hours   <= '0;
        in_ch.add_minutes <= '0;
        in_ch.add_seconds <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(build_word(0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(build_word(9999, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 0));
        send_word(build_word(9999, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        send_word(build_word(2023, 0, 15, 8, 30, 0, 0, 0, 0, 0, 0, 0));
        send_word(build_word(2023, 15, 10, 8, 30, 0, 0, 3, 0, 0, 0, 0));
        send_word(build_word(2023, 6, 0, 12, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(build_word(2023, 2, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(build_word(2024, 2, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(build_word(2023, 5, 20, 31, 63, 63, 0, 0, 0, 0, 0, 0));
        send_word(build_word(16383, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(build_word(2000, 2, 28, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        send_word(build_word(1900, 2, 28, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        send_word(build_word(2100, 2, 28, 0, 0, 0, 0, 0, 0, 24, 0, 0));
        send_word(build_word(2024, 2, 28, 0, 0, 0, 0, 0, 0, 0, 1440, 0));
        send_word(build_word(2023, 12, 31, 23, 59, 59, 0, 0, 0, 0, 0, 1));
        send_word(build_word(0, 1, 1, 0, 0, 0, 0, 0, 65535, 65535, 65535, 65535));
        send_word(build_word(0, 12, 1, 0, 0, 0, 0, 4095, 0, 0, 0, 0));
        send_word(build_word(0, 1, 1, 0, 0, 0, 9999, 11, 30, 0, 0, 0));
        send_word(build_word(16383, 15, 31, 31, 63, 63,
                             16383, 4095, 65535, 65535, 65535, 65535));
        send_word(build_word(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 65535));
        send_word(build_word(9999, 1, 1, 0, 0, 0, 0, 0, 364, 0, 0, 0));
        send_word(build_word(9999, 1, 1, 0, 0, 0, 0, 0, 365, 0, 0, 0));
        send_word(build_word(400, 2, 29, 0, 0, 0, 100, 0, 0, 0, 0, 0));

        repeat (250)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 13)
                w = build_word($urandom_range(0, 9999), $urandom_range(1, 12),
                               $urandom_range(1, 28), $urandom_range(0, 23),
                               $urandom_range(0, 59), $urandom_range(0, 59),
                               pick_amount(30, 9999), pick_amount(24, 4095),
                               pick_amount(60, 65535), pick_amount(48, 65535),
                               pick_amount(120, 65535), pick_amount(200, 65535));
            else if (kind < 16)
                w = build_word($urandom_range(0, 1) ? $urandom_range(9995, 9999)
                                                    : 4 * $urandom_range(0, 2499),
                               $urandom_range(0, 1) ? FEB : DEC,
                               $urandom_range(27, 31), 23, 59, $urandom_range(50, 59),
                               $urandom_range(0, 4), $urandom_range(0, 1),
                               $urandom_range(0, 3), $urandom_range(0, 2),
                               $urandom_range(0, 2), $urandom_range(0, 120));
            else
                w = build_word(any_bits(YEAR_W), any_bits(MONTH_W), any_bits(DAY_W),
                               any_bits(HOUR_W), any_bits(MIN_W), any_bits(SEC_W),
                               any_bits(AYEAR_W), any_bits(AMONTH_W), any_bits(ADD_W),
                               any_bits(ADD_W), any_bits(ADD_W), any_bits(ADD_W));
            send_word(w);
        end
        in_ch.valid <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (2500) @(posedge clk);
        if (board.fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("testbench failed");
        $finish;
    end

endmodule
